// ===== src/nfba_pkg.sv =====
// Shared constants, codes and control types of the next-fit block allocator.
package nfba_pkg;

  // Storage geometry
  localparam int NUM_BLOCKS = 8;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

  // Fixed field widths of the channels
  localparam int CMD_W  = 2;
  localparam int BLK_W  = 3;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 4;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADIDX = 2'd2;
  localparam logic [STAT_W-1:0] ST_SAT    = 2'd3;

  // Reset value of the active block count
  localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic do_exec;
    logic do_scan;
    logic load_out;
  } nfba_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_alloc;
    logic fit;
    logic last;
    logic out_free;
  } nfba_sts_t;

endpackage

// ===== src/nfba_ifs.sv =====
// Channel interfaces of the next-fit block allocator: input, result and configuration.
interface nfba_in_if;
  logic                             valid;
  logic                             ready;
  logic [nfba_pkg::CMD_W-1:0]       command;
  logic [nfba_pkg::BLK_W-1:0]       block;
  logic [nfba_pkg::SIZE_BITS-1:0]   amount;

  modport source (output valid, output command, output block, output amount, input ready);
  modport sink   (input valid, input command, input block, input amount, output ready);
endinterface

interface nfba_out_if;
  logic                             valid;
  logic                             ready;
  logic [nfba_pkg::STAT_W-1:0]      status;
  logic [nfba_pkg::BLK_W-1:0]       chosen_block;
  logic [nfba_pkg::SIZE_BITS-1:0]   space_left;

  modport source (output valid, output status, output chosen_block, output space_left,
                  input ready);
  modport sink   (input valid, input status, input chosen_block, input space_left,
                  output ready);
endinterface

interface nfba_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [nfba_pkg::CFG_W-1:0]       active_blocks;

  modport source (output valid, output active_blocks, input ready);
  modport sink   (input valid, input active_blocks, output ready);
endinterface

// ===== src/nfba_ctrl.sv =====
// Controller state machine of the next-fit block allocator.
module nfba_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  nfba_pkg::nfba_sts_t sts,
  output nfba_pkg::nfba_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Sequence one item: take it, run it, hand the result to the output register
  always_comb begin
    state_nxt    = state_r;
    cmd.capture  = 1'b0;
    cmd.do_exec  = 1'b0;
    cmd.do_scan  = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_RUN;
        end
      end
      S_RUN: begin
        if (sts.is_alloc) begin
          cmd.do_scan = 1'b1;
          if (sts.fit || sts.last) begin
            state_nxt = S_DONE;
          end
        end else begin
          cmd.do_exec = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/nfba_datapath.sv =====
// Datapath of the next-fit block allocator: free-space table, scan pointer and result registers.
module nfba_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  nfba_pkg::nfba_cmd_t                 cmd,
  output nfba_pkg::nfba_sts_t                 sts,
  input  logic [nfba_pkg::CMD_W-1:0]          in_command,
  input  logic [nfba_pkg::BLK_W-1:0]          in_block,
  input  logic [nfba_pkg::SIZE_BITS-1:0]      in_amount,
  nfba_cfg_if.sink                            cfg_ch,
  nfba_out_if.source                          out_ch
);

  // Stored state
  logic [nfba_pkg::SIZE_BITS-1:0] free_space_r [nfba_pkg::NUM_BLOCKS];
  logic [nfba_pkg::IDX_W-1:0]     scan_pos_r, scan_pos_nxt;
  logic [nfba_pkg::CFG_W-1:0]     active_r;

  // Captured item and scan progress
  logic [nfba_pkg::CMD_W-1:0]     cmd_r;
  logic [nfba_pkg::BLK_W-1:0]     blk_r;
  logic [nfba_pkg::SIZE_BITS-1:0] amt_r;
  logic [nfba_pkg::CNT_W-1:0]     n_r;
  logic [nfba_pkg::IDX_W-1:0]     start_r;
  logic [nfba_pkg::IDX_W-1:0]     p_r, p_nxt;
  logic [nfba_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;

  // Pending result and output register
  logic [nfba_pkg::STAT_W-1:0]    res_status_r, res_status_nxt;
  logic [nfba_pkg::BLK_W-1:0]     res_block_r, res_block_nxt;
  logic [nfba_pkg::SIZE_BITS-1:0] res_space_r, res_space_nxt;
  logic                           out_valid_r;
  logic [nfba_pkg::STAT_W-1:0]    out_status_r;
  logic [nfba_pkg::BLK_W-1:0]     out_block_r;
  logic [nfba_pkg::SIZE_BITS-1:0] out_space_r;

  // Combinational helpers
  logic [nfba_pkg::CNT_W-1:0]     eff_n;
  logic [nfba_pkg::IDX_W-1:0]     start_norm;
  logic [nfba_pkg::IDX_W-1:0]     rd_addr;
  logic [nfba_pkg::SIZE_BITS-1:0] rd_data;
  logic [nfba_pkg::SIZE_BITS:0]   sum;
  logic                           blk_bad;
  logic                           fit;
  logic                           last;
  logic [nfba_pkg::CNT_W-1:0]     p_inc;
  logic                           wr_en;
  logic [nfba_pkg::SIZE_BITS-1:0] wr_data;

  assign cfg_ch.ready = 1'b1;

  // Clamp the active count into 1 .. NUM_BLOCKS
  always_comb begin
    if (active_r == '0) begin
      eff_n = nfba_pkg::CNT_W'(1);
    end else if (active_r > nfba_pkg::CFG_W'(nfba_pkg::NUM_BLOCKS)) begin
      eff_n = nfba_pkg::CNT_W'(nfba_pkg::NUM_BLOCKS);
    end else begin
      eff_n = nfba_pkg::CNT_W'(active_r);
    end
  end

  // Restart from block 0 when the remembered position is stale
  assign start_norm = (nfba_pkg::CNT_W'(scan_pos_r) >= eff_n) ? '0 : scan_pos_r;

  // One table read a cycle: scan pointer while allocating, named block otherwise
  assign rd_addr = (cmd_r == nfba_pkg::CMD_ALLOC) ? p_r : nfba_pkg::IDX_W'(blk_r);
  assign rd_data = free_space_r[rd_addr];
  assign sum     = {1'b0, rd_data} + {1'b0, amt_r};
  assign blk_bad = (nfba_pkg::CNT_W'(blk_r) >= n_r);
  assign fit     = (rd_data >= amt_r);
  assign last    = (cnt_r == n_r - nfba_pkg::CNT_W'(1));
  assign p_inc   = nfba_pkg::CNT_W'(p_r) + nfba_pkg::CNT_W'(1);

  assign sts.is_alloc = (cmd_r == nfba_pkg::CMD_ALLOC);
  assign sts.fit      = fit;
  assign sts.last     = last;
  assign sts.out_free = !out_valid_r || out_ch.ready;

  // Execute one step of the current command
  always_comb begin
    wr_en          = 1'b0;
    wr_data        = rd_data;
    scan_pos_nxt   = scan_pos_r;
    p_nxt          = p_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_block_nxt  = res_block_r;
    res_space_nxt  = res_space_r;

    if (cmd.do_exec) begin
      if ((cmd_r == nfba_pkg::CMD_RELEASE) || (cmd_r == nfba_pkg::CMD_LOAD)) begin
        res_block_nxt = blk_r;
        if (blk_bad) begin
          res_status_nxt = nfba_pkg::ST_BADIDX;
          res_space_nxt  = '0;
        end else if (cmd_r == nfba_pkg::CMD_RELEASE) begin
          wr_en          = 1'b1;
          wr_data        = sum[nfba_pkg::SIZE_BITS] ? '1 : sum[nfba_pkg::SIZE_BITS-1:0];
          res_status_nxt = sum[nfba_pkg::SIZE_BITS] ? nfba_pkg::ST_SAT : nfba_pkg::ST_OK;
          res_space_nxt  = wr_data;
        end else begin
          wr_en          = 1'b1;
          wr_data        = amt_r;
          res_status_nxt = nfba_pkg::ST_OK;
          res_space_nxt  = amt_r;
        end
      end else begin
        res_status_nxt = nfba_pkg::ST_OK;
        res_block_nxt  = '0;
        res_space_nxt  = '0;
      end
    end

    if (cmd.do_scan) begin
      if (fit) begin
        wr_en          = 1'b1;
        wr_data        = rd_data - amt_r;
        scan_pos_nxt   = p_r;
        res_status_nxt = nfba_pkg::ST_OK;
        res_block_nxt  = nfba_pkg::BLK_W'(p_r);
        res_space_nxt  = wr_data;
      end else if (last) begin
        scan_pos_nxt   = start_r;
        res_status_nxt = nfba_pkg::ST_NOFIT;
        res_block_nxt  = nfba_pkg::BLK_W'(start_r);
        res_space_nxt  = '0;
      end else begin
        p_nxt   = (p_inc == n_r) ? '0 : p_r + nfba_pkg::IDX_W'(1);
        cnt_nxt = cnt_r + nfba_pkg::CNT_W'(1);
      end
    end

    if (cmd.capture) begin
      p_nxt   = start_norm;
      cnt_nxt = '0;
    end
  end

  // Hold the free-space table, position and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < nfba_pkg::NUM_BLOCKS; i++) begin
        free_space_r[i] <= '0;
      end
      scan_pos_r <= '0;
      active_r   <= nfba_pkg::ACTIVE_RESET;
    end else begin
      if (wr_en) begin
        free_space_r[rd_addr] <= wr_data;
      end
      scan_pos_r <= scan_pos_nxt;
      if (cfg_ch.valid) begin
        active_r <= cfg_ch.active_blocks;
      end
    end
  end

  // Capture the item and advance the scan
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= in_command;
      blk_r   <= in_block;
      amt_r   <= in_amount;
      n_r     <= eff_n;
      start_r <= start_norm;
    end
    p_r          <= p_nxt;
    cnt_r        <= cnt_nxt;
    res_status_r <= res_status_nxt;
    res_block_r  <= res_block_nxt;
    res_space_r  <= res_space_nxt;
  end

  // Output register: load a finished result, drop it on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_block_r  <= res_block_r;
      out_space_r  <= res_space_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.chosen_block = out_block_r;
  assign out_ch.space_left   = out_space_r;

  // The scan never runs past the last active block
  a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_scan |-> (cnt_r < n_r) && (nfba_pkg::CNT_W'(p_r) < n_r))
    else $error("scan ran past active blocks");

  // A fit leaves the remembered position on the chosen block
  a_fit_moves_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.do_scan && fit) |=> (scan_pos_r == $past(p_r)))
    else $error("scan position not updated on fit");

  // A captured active count is always usable
  a_n_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.capture) |-> (n_r != '0) && (n_r <= nfba_pkg::NUM_BLOCKS))
    else $error("captured active count out of range");

  // A failed allocation reports no space and the start block
  a_nofit_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.do_scan && !fit && last) |=>
      (res_space_r == '0) && (res_block_r == nfba_pkg::BLK_W'($past(start_r))))
    else $error("bad no-fit result");

endmodule

// ===== src/next_fit_block_allocator_core.sv =====
// Top level of the next-fit block allocator: controller plus datapath.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   command[1:0], block[2:0], amount[15:0]
//   out_ch   out  valid/ready   status[1:0], chosen_block[2:0], space_left[15:0]
//   cfg_ch   in   valid/ready   active_blocks[3:0] (ready always high)
//
// Release, load and unused commands are captured in S_IDLE, executed in S_RUN and
// moved to the output register in S_DONE, which waits until that register is free.
// An allocate examines one block a cycle through the single table read port in
// S_RUN, until a block fits or the last active block has been examined; it then
// passes through S_DONE in the same way.
// One item is in flight at a time; the output register lets the next item
// transfer in while a result still waits on out_ch.
// Reset (rst_n low, synchronous) clears the table, the scan position and the
// output valid, and sets the active count to 8.
module next_fit_block_allocator_core (
  input  logic       clk,
  input  logic       rst_n,
  nfba_in_if.sink    in_ch,
  nfba_out_if.source out_ch,
  nfba_cfg_if.sink   cfg_ch
);

  nfba_pkg::nfba_cmd_t cmd;
  nfba_pkg::nfba_sts_t sts;

  nfba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nfba_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_command (in_ch.command),
    .in_block   (in_ch.block),
    .in_amount  (in_ch.amount),
    .cfg_ch     (cfg_ch),
    .out_ch     (out_ch)
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench of the next-fit block allocator core.
`timescale 1ns / 100ps

module tb;

  localparam int          CLK_HALF     = 4;
  localparam int          RESET_CYCLES = 6;
  localparam int          DRAIN_CYCLES = 12;
  localparam int          CYCLE_LIMIT  = 300000;
  localparam int          PHASE_ITEMS  = 100;
  localparam int          HOLD_AT      = 250;
  localparam int          HOLD_CYCLES  = 400;
  localparam logic [nfba_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [nfba_pkg::CMD_W-1:0]     command;
    logic [nfba_pkg::BLK_W-1:0]     block;
    logic [nfba_pkg::SIZE_BITS-1:0] amount;
  } alloc_req_t;

  typedef struct packed {
    logic [nfba_pkg::STAT_W-1:0]    status;
    logic [nfba_pkg::BLK_W-1:0]     chosen_block;
    logic [nfba_pkg::SIZE_BITS-1:0] space_left;
  } alloc_resp_t;

  logic clk = 1'b0;
  logic rst_n;

  nfba_in_if  in_ch ();
  nfba_out_if out_ch ();
  nfba_cfg_if cfg_ch ();

  next_fit_block_allocator_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state: free-space table, scan position, active count
  logic [nfba_pkg::SIZE_BITS-1:0] free_tbl [nfba_pkg::NUM_BLOCKS];
  int                             scan_pos;
  logic [nfba_pkg::CFG_W-1:0]     active_cfg = nfba_pkg::ACTIVE_RESET;

  alloc_req_t  pending_reqs [$];
  alloc_resp_t expected_results [$];
  int          items_queued = 0;
  int          results_seen = 0;
  int          error_count  = 0;
  int          cycle_count  = 0;

  // Driver and receiver locals
  alloc_req_t  drv_req;
  alloc_req_t  mon_req;
  alloc_resp_t got_resp;
  alloc_resp_t want_resp;
  int          burst_left;
  int          gap_left;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          stall_mode = 0;
  int          mode_left = 0;
  logic        rx_ready;

  always #CLK_HALF clk = ~clk;

  function automatic int eff_active();
    if (active_cfg == 0) return 1;
    if (active_cfg > nfba_pkg::NUM_BLOCKS) return nfba_pkg::NUM_BLOCKS;
    return int'(active_cfg);
  endfunction

  // Compute the result of one command and update the table
  function automatic alloc_resp_t predict_alloc_result(alloc_req_t rq);
    alloc_resp_t r;
    int          n;
    int          start;
    int          p;
    bit          found;
    logic [nfba_pkg::SIZE_BITS:0] sum;
    n = eff_active();
    r.status       = nfba_pkg::ST_OK;
    r.chosen_block = '0;
    r.space_left   = '0;
    case (rq.command)
      nfba_pkg::CMD_ALLOC: begin
        start = (scan_pos >= n) ? 0 : scan_pos;
        found = 1'b0;
        for (int i = 0; i < n && !found; i++) begin
          p = start + i;
          if (p >= n) p -= n;
          if (free_tbl[p] >= rq.amount) begin
            free_tbl[p]    = free_tbl[p] - rq.amount;
            scan_pos       = p;
            r.chosen_block = nfba_pkg::BLK_W'(p);
            r.space_left   = free_tbl[p];
            found          = 1'b1;
          end
        end
        if (!found) begin
          scan_pos       = start;
          r.status       = nfba_pkg::ST_NOFIT;
          r.chosen_block = nfba_pkg::BLK_W'(start);
        end
      end
      nfba_pkg::CMD_RELEASE, nfba_pkg::CMD_LOAD: begin
        r.chosen_block = rq.block;
        if (int'(rq.block) >= n) begin
          r.status = nfba_pkg::ST_BADIDX;
        end else if (rq.command == nfba_pkg::CMD_RELEASE) begin
          sum = {1'b0, free_tbl[rq.block]} + {1'b0, rq.amount};
          if (sum[nfba_pkg::SIZE_BITS]) begin
            free_tbl[rq.block] = '1;
            r.status           = nfba_pkg::ST_SAT;
          end else begin
            free_tbl[rq.block] = sum[nfba_pkg::SIZE_BITS-1:0];
          end
          r.space_left = free_tbl[rq.block];
        end else begin
          free_tbl[rq.block] = rq.amount;
          r.space_left       = rq.amount;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_req(logic [nfba_pkg::CMD_W-1:0] cmd, logic [nfba_pkg::BLK_W-1:0] blk,
                           logic [nfba_pkg::SIZE_BITS-1:0] amt);
    alloc_req_t rq;
    rq.command = cmd;
    rq.block   = blk;
    rq.amount  = amt;
    pending_reqs.push_back(rq);
    items_queued++;
  endtask

  // Hold until every queued item has produced its result, then let the core settle
  task automatic wait_until_drained();
    while (results_seen != items_queued) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_active_blocks(logic [nfba_pkg::CFG_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.active_blocks <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    active_cfg = value;
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly well-formed commands on active blocks, with some noise
  task automatic queue_random_phase(int count);
    int                             n;
    int                             sel;
    int                             kind;
    logic [nfba_pkg::CMD_W-1:0]     cmd;
    logic [nfba_pkg::BLK_W-1:0]     blk;
    logic [nfba_pkg::SIZE_BITS-1:0] amt;
    n = eff_active();
    for (int k = 0; k < count; k++) begin
      sel  = $urandom_range(0, 99);
      kind = $urandom_range(0, 9);
      blk  = nfba_pkg::BLK_W'($urandom_range(0, n - 1));
      case (kind)
        0:          amt = '0;
        1:          amt = '1;
        2, 3, 4, 5: amt = nfba_pkg::SIZE_BITS'($urandom_range(0, 255));
        6, 7:       amt = nfba_pkg::SIZE_BITS'($urandom_range(0, 4095));
        default:    amt = nfba_pkg::SIZE_BITS'($urandom);
      endcase
      if (sel < 45) begin
        cmd = nfba_pkg::CMD_ALLOC;
        if ($urandom_range(0, 1)) blk = nfba_pkg::BLK_W'($urandom);
      end else if (sel < 65) begin
        cmd = nfba_pkg::CMD_RELEASE;
      end else if (sel < 88) begin
        cmd = nfba_pkg::CMD_LOAD;
        if ($urandom_range(0, 2) != 0) amt = nfba_pkg::SIZE_BITS'($urandom);
      end else if (sel < 95) begin
        cmd = $urandom_range(0, 1) ? nfba_pkg::CMD_RELEASE : nfba_pkg::CMD_LOAD;
        blk = nfba_pkg::BLK_W'($urandom);
      end else begin
        cmd = CMD_SPARE;
        blk = nfba_pkg::BLK_W'($urandom);
        amt = nfba_pkg::SIZE_BITS'($urandom);
      end
      queue_req(cmd, blk, amt);
    end
  endtask

  // Input driver: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        drv_req = pending_reqs.pop_front();
        in_ch.command <= drv_req.command;
        in_ch.block   <= drv_req.block;
        in_ch.amount  <= drv_req.amount;
        in_ch.valid   <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(0, 12);
          gap_left   = $urandom_range(1, 8);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Input monitor: predict the result of each accepted transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < nfba_pkg::NUM_BLOCKS; i++) free_tbl[i] = '0;
      scan_pos = 0;
    end else if (in_ch.valid && in_ch.ready) begin
      mon_req.command = in_ch.command;
      mon_req.block   = in_ch.block;
      mon_req.amount  = in_ch.amount;
      expected_results.push_back(predict_alloc_result(mon_req));
    end
  end

  // Receiver: stall pattern that changes mode, plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b1;
    end else begin
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rx_ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(16, 96);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0:       rx_ready = 1'b1;
          1:       rx_ready = ($urandom_range(0, 3) != 0);
          2:       rx_ready = ($urandom_range(0, 1) != 0);
          default: rx_ready = ($urandom_range(0, 3) == 0);
        endcase
      end
      out_ch.ready <= rx_ready;
    end
  end

  // Output monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_resp.status       = out_ch.status;
      got_resp.chosen_block = out_ch.chosen_block;
      got_resp.space_left   = out_ch.space_left;
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d block %0d space %0d",
               got_resp.status, got_resp.chosen_block, got_resp.space_left);
        error_count++;
      end else begin
        want_resp = expected_results.pop_front();
        if (got_resp.status !== want_resp.status) begin
          $error("status: expected %0d, got %0d", want_resp.status, got_resp.status);
          error_count++;
        end
        if (got_resp.chosen_block !== want_resp.chosen_block) begin
          $error("chosen_block: expected %0d, got %0d",
                 want_resp.chosen_block, got_resp.chosen_block);
          error_count++;
        end
        if (got_resp.space_left !== want_resp.space_left) begin
          $error("space_left: expected %0d, got %0d",
                 want_resp.space_left, got_resp.space_left);
          error_count++;
        end
      end
      results_seen++;
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stimulus sequence
  initial begin
    logic [nfba_pkg::CFG_W-1:0] phase_cfg [10];
    phase_cfg = '{4'd15, 4'd1, 4'd8, 4'd5, 4'd9, 4'd2, 4'd8, 4'd6, 4'd4, 4'd8};

    rst_n                = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.active_blocks = nfba_pkg::ACTIVE_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table, all eight blocks: zero-size fit, misses, saturation, wrap
    queue_req(nfba_pkg::CMD_ALLOC,   3'd0, 16'd0);
    queue_req(nfba_pkg::CMD_ALLOC,   3'd5, 16'd1);
    queue_req(CMD_SPARE,             3'd7, 16'hFFFF);
    queue_req(nfba_pkg::CMD_LOAD,    3'd0, 16'hFFFF);
    queue_req(nfba_pkg::CMD_LOAD,    3'd1, 16'd100);
    queue_req(nfba_pkg::CMD_LOAD,    3'd7, 16'd1000);
    queue_req(nfba_pkg::CMD_RELEASE, 3'd0, 16'd1);
    queue_req(nfba_pkg::CMD_RELEASE, 3'd1, 16'd50);
    queue_req(nfba_pkg::CMD_RELEASE, 3'd2, 16'd0);
    queue_req(nfba_pkg::CMD_ALLOC,   3'd7, 16'hFFFF);
    queue_req(nfba_pkg::CMD_ALLOC,   3'd0, 16'd120);
    queue_req(nfba_pkg::CMD_ALLOC,   3'd0, 16'd500);
    queue_req(nfba_pkg::CMD_ALLOC,   3'd0, 16'd600);
    queue_req(nfba_pkg::CMD_ALLOC,   3'd0, 16'd0);
    wait_until_drained();

    // Shrink to three blocks: scan position is now stale, high indexes are bad
    write_active_blocks(4'd3);
    queue_req(nfba_pkg::CMD_ALLOC,   3'd0, 16'd40000);
    queue_req(nfba_pkg::CMD_ALLOC,   3'd0, 16'd10);
    queue_req(nfba_pkg::CMD_LOAD,    3'd5, 16'd7);
    queue_req(nfba_pkg::CMD_RELEASE, 3'd7, 16'hFFFF);
    queue_req(nfba_pkg::CMD_LOAD,    3'd2, 16'hFFFF);
    queue_req(nfba_pkg::CMD_RELEASE, 3'd3, 16'd5);
    queue_req(nfba_pkg::CMD_RELEASE, 3'd2, 16'hFFFF);
    queue_req(nfba_pkg::CMD_ALLOC,   3'd0, 16'hFFFF);
    wait_until_drained();

    // Zero active count behaves as a single block
    write_active_blocks(4'd0);
    queue_req(nfba_pkg::CMD_ALLOC,   3'd0, 16'd0);
    queue_req(nfba_pkg::CMD_LOAD,    3'd1, 16'd9);
    queue_req(nfba_pkg::CMD_LOAD,    3'd0, 16'd5);
    queue_req(nfba_pkg::CMD_ALLOC,   3'd0, 16'd5);
    wait_until_drained();

    // Random phases over a range of active counts
    foreach (phase_cfg[k]) begin
      write_active_blocks(phase_cfg[k]);
      queue_random_phase(PHASE_ITEMS);
      wait_until_drained();
    end

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
